// ----- hw/rtl/rcpw_pkg.sv -----
// Shared types and constants for the pulse width capture and mixer block.
package rcpw_pkg;

   localparam int CHANNELS  = 6;
   localparam int CH_W      = 3;
   localparam int STAMP_W   = 16;
   localparam int WIDTH_W   = 22;
   localparam int MOTOR_W   = 24;
   localparam int RELOAD_W  = 16;

   localparam logic [RELOAD_W-1:0] RELOAD_RESET = 16'hFFFF;
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = 22'h3F_FFFF;

   localparam logic [CH_W-1:0] CH_ROLL   = 3'd0;
   localparam logic [CH_W-1:0] CH_PITCH  = 3'd1;
   localparam logic [CH_W-1:0] CH_AUX1   = 3'd2;
   localparam logic [CH_W-1:0] CH_AUX2   = 3'd3;
   localparam logic [CH_W-1:0] CH_THRUST = 3'd4;
   localparam logic [CH_W-1:0] CH_YAW    = 3'd5;

   typedef enum logic [1:0] {
      CMD_OVERFLOW = 2'd0,
      CMD_CAPTURE  = 2'd1,
      CMD_MIX      = 2'd2
   } cmd_type;

   typedef enum logic {
      KIND_WIDTH = 1'b0,
      KIND_MIX   = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [CH_W-1:0]        channel;
      logic [STAMP_W-1:0]     capture_value;
   } stage_item_type;

endpackage

// ----- hw/rtl/rcpw_if.sv -----
// Request and response channel interfaces.
interface rcpw_req_if
   import rcpw_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [1:0]          cmd;
   logic [CH_W-1:0]     channel;
   logic [STAMP_W-1:0]  capture_value;

   modport source (output valid, output cmd, output channel, output capture_value,
                   input ready);
   modport sink   (input valid, input cmd, input channel, input capture_value,
                   output ready);
endinterface

interface rcpw_rsp_if
   import rcpw_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [CH_W-1:0]            out_channel;
   logic [WIDTH_W-1:0]         width;
   logic signed [MOTOR_W-1:0]  motor_1;
   logic signed [MOTOR_W-1:0]  motor_2;
   logic signed [MOTOR_W-1:0]  motor_3;
   logic signed [MOTOR_W-1:0]  motor_4;
   logic [WIDTH_W-1:0]         aux_1;
   logic [WIDTH_W-1:0]         aux_2;

   modport source (output valid, output kind, output out_channel, output width,
                   output motor_1, output motor_2, output motor_3, output motor_4,
                   output aux_1, output aux_2, input ready);
   modport sink   (input valid, input kind, input out_channel, input width,
                   input motor_1, input motor_2, input motor_3, input motor_4,
                   input aux_1, input aux_2, output ready);
endinterface

// ----- hw/rtl/rc_pulse_width_capture_mixer.sv -----
// Top level of the six channel pulse width capture and motor mixer.
//
//   port        dir   handshake          payload
//   req_bus     in    valid/ready        cmd, channel, capture_value
//   rsp_bus     out   valid/ready        kind, out_channel, width, motor_1..4, aux_1..2
//   csr_*       in    write enable       reload_value (16 bit)
//
// One word per cycle is accepted while req_bus.ready is high; a result passes the
// stage register, then the output register. Arm state and wrap counts sit in flops,
// start stamps in a memory with a registered read. The wrap product is formed on
// accept, width or mix in the result stage. A full, unread output register stalls
// the result stage; req_bus.ready drops once that stage also holds a word.
// Reset is synchronous; the stamp memory needs no clearing pass.
module rc_pulse_width_capture_mixer
   import rcpw_pkg::*;
#(
   parameter int WRAP_LIMIT = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   rcpw_req_if.sink             req_bus,
   rcpw_rsp_if.source           rsp_bus,
   input  logic                 csr_write_enable,
   input  logic [RELOAD_W-1:0]  csr_write_data
);

   localparam int ProdW = $clog2(WRAP_LIMIT + 1) + RELOAD_W + 1;

   logic                advance;
   logic                s1_valid;
   stage_item_type      s1_item;
   logic [STAMP_W-1:0]  s1_start;
   logic [ProdW-1:0]    s1_prod;

   rcpw_capture #(
      .WRAP_LIMIT (WRAP_LIMIT)
   ) u_capture (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .advance          (advance),
      .s1_valid         (s1_valid),
      .s1_item          (s1_item),
      .s1_start         (s1_start),
      .s1_prod          (s1_prod)
   );

   rcpw_result #(
      .WRAP_LIMIT (WRAP_LIMIT)
   ) u_result (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_item  (s1_item),
      .s1_start (s1_start),
      .s1_prod  (s1_prod),
      .advance  (advance),
      .rsp      (rsp_bus)
   );

endmodule

// ----- hw/rtl/rcpw_capture.sv -----
// Capture stage: arm and wrap state, start stamp memory, wrap product.
module rcpw_capture
   import rcpw_pkg::*;
#(
   parameter int WRAP_LIMIT = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   rcpw_req_if.sink                req,
   input  logic                    csr_write_enable,
   input  logic [RELOAD_W-1:0]     csr_write_data,
   input  logic                    advance,
   output logic                    s1_valid,
   output stage_item_type          s1_item,
   output logic [STAMP_W-1:0]      s1_start,
   output logic [$clog2(WRAP_LIMIT+1)+RELOAD_W:0] s1_prod
);

   localparam int WrapW = $clog2(WRAP_LIMIT + 1);
   localparam int ProdW = WrapW + RELOAD_W + 1;
   localparam logic [WrapW-1:0] WrapMax = WrapW'(WRAP_LIMIT);

   logic [RELOAD_W-1:0] reload_ff, reload_in;
   logic [CHANNELS-1:0] armed_ff, armed_in;
   logic [WrapW-1:0]    wrap_ff [CHANNELS];
   logic [WrapW-1:0]    wrap_in [CHANNELS];
   logic [STAMP_W-1:0]  start_mem [CHANNELS];
   logic [STAMP_W-1:0]  start_ff;
   logic                s1_valid_ff, s1_valid_in;
   stage_item_type      item_ff, item_in;
   logic [ProdW-1:0]    prod_ff, prod_in;

   logic                accept;
   logic                ch_ok;
   logic                is_capture;
   logic                arm_write;
   logic                measure;
   logic                mix;
   logic [CH_W-1:0]     ch;

   assign ch         = req.channel;
   assign req.ready  = !s1_valid_ff || advance;
   assign accept     = req.valid && req.ready;
   assign ch_ok      = (ch < CH_W'(CHANNELS));
   assign is_capture = accept && (req.cmd == CMD_CAPTURE) && ch_ok;
   assign arm_write  = is_capture && !armed_ff[ch];
   assign measure    = is_capture && armed_ff[ch];
   assign mix        = accept && (req.cmd == CMD_MIX);

   assign reload_in = csr_write_enable ? csr_write_data : reload_ff;

   always_comb begin
      armed_in = armed_ff;
      for (int i = 0; i < CHANNELS; i++) begin
         wrap_in[i] = wrap_ff[i];
      end
      if (accept && (req.cmd == CMD_OVERFLOW)) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (armed_ff[i]) begin
               if (wrap_ff[i] >= WrapMax) begin
                  armed_in[i] = 1'b0;
                  wrap_in[i]  = '0;
               end else begin
                  wrap_in[i] = wrap_ff[i] + WrapW'(1);
               end
            end
         end
      end
      if (arm_write) begin
         armed_in[ch] = 1'b1;
         wrap_in[ch]  = '0;
      end
      if (measure) begin
         armed_in[ch] = 1'b0;
         wrap_in[ch]  = '0;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !advance;
      item_in     = item_ff;
      prod_in     = prod_ff;
      if (accept) begin
         s1_valid_in           = measure || mix;
         item_in.kind          = mix ? KIND_MIX : KIND_WIDTH;
         item_in.channel       = ch;
         item_in.capture_value = req.capture_value;
         prod_in = ProdW'(ProdW'(measure ? wrap_ff[ch] : '0)
                          * ProdW'({1'b0, reload_ff} + 17'd1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff   <= RELOAD_RESET;
         armed_ff    <= '0;
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            wrap_ff[i] <= '0;
         end
      end else begin
         reload_ff   <= reload_in;
         armed_ff    <= armed_in;
         s1_valid_ff <= s1_valid_in;
         for (int i = 0; i < CHANNELS; i++) begin
            wrap_ff[i] <= wrap_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (arm_write) begin
         start_mem[ch] <= req.capture_value;
      end
      if (measure) begin
         start_ff <= start_mem[ch];
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_item  = item_ff;
   assign s1_start = start_ff;
   assign s1_prod  = prod_ff;

`ifndef SYNTH
   a_measure_enters: assert property (@(posedge clock) disable iff (reset)
      measure |=> s1_valid_ff)
      else $error("measurement did not enter result stage");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(item_ff) && $stable(prod_ff))
      else $error("stalled stage word changed");
   a_arm_sets: assert property (@(posedge clock) disable iff (reset)
      arm_write |=> armed_ff[$past(ch)])
      else $error("arming capture did not arm channel");
`endif

endmodule

// ----- hw/rtl/rcpw_result.sv -----
// Result stage: width compute, last width store, motor mix, output register.
module rcpw_result
   import rcpw_pkg::*;
#(
   parameter int WRAP_LIMIT = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    s1_valid,
   input  stage_item_type          s1_item,
   input  logic [STAMP_W-1:0]      s1_start,
   input  logic [$clog2(WRAP_LIMIT+1)+RELOAD_W:0] s1_prod,
   output logic                    advance,
   rcpw_rsp_if.source              rsp
);

   localparam int WrapW = $clog2(WRAP_LIMIT + 1);
   localparam int ProdW = WrapW + RELOAD_W + 1;
   localparam int SumW  = (ProdW + 2 > MOTOR_W) ? ProdW + 2 : MOTOR_W;

   logic [WIDTH_W-1:0]        last_ff [CHANNELS];
   logic [WIDTH_W-1:0]        last_in [CHANNELS];
   logic                      out_valid_ff, out_valid_in;
   logic                      kind_ff, kind_in;
   logic [CH_W-1:0]           chan_ff, chan_in;
   logic [WIDTH_W-1:0]        width_ff, width_in;
   logic [MOTOR_W-1:0]        m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in, m4_ff, m4_in;
   logic [WIDTH_W-1:0]        aux1_ff, aux1_in, aux2_ff, aux2_in;

   logic signed [SumW-1:0]    wsum;
   logic [WIDTH_W-1:0]        wsat;
   logic [MOTOR_W-1:0]        roll, pitch, thrust, yaw;
   logic                      move;

   assign advance = !out_valid_ff || rsp.ready;
   assign move    = s1_valid && advance;

   assign wsum = $signed(SumW'(s1_prod)) + $signed(SumW'(s1_item.capture_value))
                 - $signed(SumW'(s1_start));

   always_comb begin
      priority if (wsum < $signed(SumW'(0))) begin
         wsat = '0;
      end else if (wsum > $signed(SumW'(WIDTH_MAX))) begin
         wsat = WIDTH_MAX;
      end else begin
         wsat = wsum[WIDTH_W-1:0];
      end
   end

   assign roll   = MOTOR_W'(last_ff[CH_ROLL]);
   assign pitch  = MOTOR_W'(last_ff[CH_PITCH]);
   assign thrust = MOTOR_W'(last_ff[CH_THRUST]);
   assign yaw    = MOTOR_W'(last_ff[CH_YAW]);

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         last_in[i] = last_ff[i];
      end
      out_valid_in = out_valid_ff && !rsp.ready;
      kind_in  = kind_ff;
      chan_in  = chan_ff;
      width_in = width_ff;
      m1_in    = m1_ff;
      m2_in    = m2_ff;
      m3_in    = m3_ff;
      m4_in    = m4_ff;
      aux1_in  = aux1_ff;
      aux2_in  = aux2_ff;
      if (move) begin
         out_valid_in = 1'b1;
         unique case (s1_item.kind)
            KIND_WIDTH: begin
               last_in[s1_item.channel] = wsat;
               kind_in  = KIND_WIDTH;
               chan_in  = s1_item.channel;
               width_in = wsat;
               m1_in    = '0;
               m2_in    = '0;
               m3_in    = '0;
               m4_in    = '0;
               aux1_in  = '0;
               aux2_in  = '0;
            end
            KIND_MIX: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  last_in[i] = '0;
               end
               kind_in  = KIND_MIX;
               chan_in  = '0;
               width_in = '0;
               m1_in    = thrust + yaw - pitch;
               m2_in    = thrust + roll - yaw;
               m3_in    = thrust + pitch - yaw;
               m4_in    = thrust + yaw - roll;
               aux1_in  = last_ff[CH_AUX1];
               aux2_in  = last_ff[CH_AUX2];
            end
            default: begin
               kind_in = KIND_WIDTH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < CHANNELS; i++) begin
            last_ff[i] <= last_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      chan_ff  <= chan_in;
      width_ff <= width_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      m3_ff    <= m3_in;
      m4_ff    <= m4_in;
      aux1_ff  <= aux1_in;
      aux2_ff  <= aux2_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.out_channel = chan_ff;
   assign rsp.width       = width_ff;
   assign rsp.motor_1     = $signed(m1_ff);
   assign rsp.motor_2     = $signed(m2_ff);
   assign rsp.motor_3     = $signed(m3_ff);
   assign rsp.motor_4     = $signed(m4_ff);
   assign rsp.aux_1       = aux1_ff;
   assign rsp.aux_2       = aux2_ff;

`ifndef SYNTH
   a_move_shows: assert property (@(posedge clock) disable iff (reset)
      move |=> out_valid_ff)
      else $error("stage word did not reach output");
   a_mix_clears: assert property (@(posedge clock) disable iff (reset)
      move && (s1_item.kind == KIND_MIX) |=> last_ff[CH_ROLL] == '0
         && last_ff[CH_PITCH] == '0 && last_ff[CH_AUX1] == '0
         && last_ff[CH_AUX2] == '0 && last_ff[CH_THRUST] == '0 && last_ff[CH_YAW] == '0)
      else $error("mix did not clear widths");
   a_width_word_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (kind_ff == KIND_WIDTH) |-> m1_ff == '0 && aux1_ff == '0
         && aux2_ff == '0)
      else $error("width word carries mix fields");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the pulse width capture and motor mixer.
module tb_top;
   import rcpw_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         WRAP_CAP     = 63;
   localparam int         GAP_MAX      = 18;
   localparam int         DRAIN_CYCLES = 8;
   localparam int         PHASE_WORDS  = 240;
   localparam int         PHASES       = 6;

   typedef struct packed {
      kind_type                   kind;
      logic [CH_W-1:0]            out_channel;
      logic [WIDTH_W-1:0]         width;
      logic signed [MOTOR_W-1:0]  motor_1;
      logic signed [MOTOR_W-1:0]  motor_2;
      logic signed [MOTOR_W-1:0]  motor_3;
      logic signed [MOTOR_W-1:0]  motor_4;
      logic [WIDTH_W-1:0]         aux_1;
      logic [WIDTH_W-1:0]         aux_2;
   } rc_result_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [CH_W-1:0]     chan;
      logic [STAMP_W-1:0]  stamp;
      logic                typed;
      rc_result_type       want;
   } stim_row_type;

   localparam rc_result_type MIX_CLEARED = '{KIND_MIX, 3'd0, 22'd0, 24'sd0, 24'sd0, 24'sd0,
                                             24'sd0, 22'd0, 22'd0};

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write_enable;
   logic [RELOAD_W-1:0]  csr_write_data;

   rcpw_req_if req_bus ();
   rcpw_rsp_if rsp_bus ();

   rc_pulse_width_capture_mixer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   bit             armed_q  [CHANNELS];
   int             wraps_q  [CHANNELS];
   int             start_q  [CHANNELS];
   int             width_q  [CHANNELS];
   int             reload_q;
   rc_result_type  pending_results [$];
   int             mismatch_count = 0;
   int             sent_words     = 0;
   bit             send_gaps_on   = 1'b1;
   bit             recv_stalls_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1500000;
      $display("simulation failed");
      $finish;
   end

   function automatic rc_result_type measured(input logic [CH_W-1:0] ch, input int w);
      rc_result_type res;
      res             = MIX_CLEARED;
      res.kind        = KIND_WIDTH;
      res.out_channel = ch;
      res.width       = WIDTH_W'(w);
      return res;
   endfunction

   function automatic logic [STAMP_W-1:0] draw_stamp();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         return '0;
      end
      if (pick == 1) begin
         return '1;
      end
      return STAMP_W'($urandom);
   endfunction

   task automatic track_pulse_word(input logic [1:0] c, input logic [CH_W-1:0] ch,
                                   input logic [STAMP_W-1:0] cap, output bit produced,
                                   output rc_result_type res);
      int w;
      int roll;
      int pitch;
      int thrust;
      int yaw;
      produced = 1'b0;
      res      = '0;
      case (c)
         CMD_OVERFLOW: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (armed_q[i]) begin
                  if (wraps_q[i] >= WRAP_CAP) begin
                     armed_q[i] = 1'b0;
                     wraps_q[i] = 0;
                     start_q[i] = 0;
                  end else begin
                     wraps_q[i]++;
                  end
               end
            end
         end
         CMD_CAPTURE: begin
            if (int'(ch) < CHANNELS) begin
               if (!armed_q[ch]) begin
                  armed_q[ch] = 1'b1;
                  wraps_q[ch] = 0;
                  start_q[ch] = int'(cap);
               end else begin
                  w = wraps_q[ch] * (reload_q + 1) + int'(cap) - start_q[ch];
                  if (w < 0) begin
                     w = 0;
                  end
                  if (w > int'(WIDTH_MAX)) begin
                     w = int'(WIDTH_MAX);
                  end
                  width_q[ch] = w;
                  armed_q[ch] = 1'b0;
                  wraps_q[ch] = 0;
                  produced    = 1'b1;
                  res         = measured(ch, w);
               end
            end
         end
         CMD_MIX: begin
            roll        = width_q[CH_ROLL];
            pitch       = width_q[CH_PITCH];
            thrust      = width_q[CH_THRUST];
            yaw         = width_q[CH_YAW];
            produced    = 1'b1;
            res.kind    = KIND_MIX;
            res.motor_1 = MOTOR_W'(thrust + yaw - pitch);
            res.motor_2 = MOTOR_W'(thrust + roll - yaw);
            res.motor_3 = MOTOR_W'(thrust + pitch - yaw);
            res.motor_4 = MOTOR_W'(thrust + yaw - roll);
            res.aux_1   = WIDTH_W'(width_q[CH_AUX1]);
            res.aux_2   = WIDTH_W'(width_q[CH_AUX2]);
            for (int i = 0; i < CHANNELS; i++) begin
               width_q[i] = 0;
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic report(input string field, input longint want, input longint got);
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
   endtask

   task automatic check_result();
      rc_result_type want;
      if (pending_results.size() == 0) begin
         $error("result word with nothing pending");
         mismatch_count++;
      end else begin
         want = pending_results.pop_front();
         if (rsp_bus.kind !== want.kind) report("kind", want.kind, rsp_bus.kind);
         if (rsp_bus.out_channel !== want.out_channel)
            report("out_channel", want.out_channel, rsp_bus.out_channel);
         if (rsp_bus.width !== want.width) report("width", want.width, rsp_bus.width);
         if (rsp_bus.motor_1 !== want.motor_1) report("motor_1", want.motor_1, rsp_bus.motor_1);
         if (rsp_bus.motor_2 !== want.motor_2) report("motor_2", want.motor_2, rsp_bus.motor_2);
         if (rsp_bus.motor_3 !== want.motor_3) report("motor_3", want.motor_3, rsp_bus.motor_3);
         if (rsp_bus.motor_4 !== want.motor_4) report("motor_4", want.motor_4, rsp_bus.motor_4);
         if (rsp_bus.aux_1 !== want.aux_1) report("aux_1", want.aux_1, rsp_bus.aux_1);
         if (rsp_bus.aux_2 !== want.aux_2) report("aux_2", want.aux_2, rsp_bus.aux_2);
      end
   endtask

   task automatic send_word(input logic [1:0] c, input logic [CH_W-1:0] ch,
                            input logic [STAMP_W-1:0] cap, input logic typed,
                            input rc_result_type typed_result);
      int             gap;
      bit             produced;
      rc_result_type  res;
      if (sent_words % 50 == 0) begin
         send_gaps_on = ($urandom_range(0, 3) != 0);
      end
      gap = send_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= c;
      req_bus.channel       <= ch;
      req_bus.capture_value <= cap;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_pulse_word(c, ch, cap, produced, res);
      if (produced) begin
         pending_results.push_back(typed ? typed_result : res);
      end
      sent_words++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reload(input logic [RELOAD_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      reload_q = int'(value);
   endtask

   task automatic run_random(input int words);
      int               done;
      int               pick;
      int               laps;
      logic [CH_W-1:0]  ch;
      logic [STAMP_W-1:0] stamp;
      done = 0;
      while (done < words) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            // long pulse: arm if idle, run the wrap count to near, at or past its cap, then close
            ch = CH_W'($urandom_range(0, CHANNELS - 1));
            if (!armed_q[ch]) begin
               stamp = $urandom_range(0, 1) ? '0 : draw_stamp();
               send_word(CMD_CAPTURE, ch, stamp, 1'b0, '0);
               done++;
            end
            laps = $urandom_range(0, 1) ? WRAP_CAP : $urandom_range(WRAP_CAP - 8, WRAP_CAP + 3);
            repeat (laps) begin
               send_word(CMD_OVERFLOW, CH_W'($urandom_range(0, 7)), draw_stamp(), 1'b0, '0);
            end
            stamp = $urandom_range(0, 1) ? '1 : draw_stamp();
            send_word(CMD_CAPTURE, ch, stamp, 1'b0, '0);
            done += laps + 1;
         end else if (pick < 8) begin
            if ($urandom_range(0, 1) != 0) begin
               send_word(CMD_UNUSED, CH_W'($urandom_range(0, 7)), STAMP_W'($urandom),
                         1'b0, '0);
            end else begin
               send_word(CMD_CAPTURE, CH_W'($urandom_range(CHANNELS, 7)),
                         STAMP_W'($urandom), 1'b0, '0);
            end
            done++;
         end else if (pick < 16) begin
            send_word(CMD_MIX, CH_W'($urandom_range(0, 7)), draw_stamp(), 1'b0, '0);
            done++;
         end else if (pick < 40) begin
            send_word(CMD_OVERFLOW, CH_W'($urandom_range(0, 7)), draw_stamp(), 1'b0, '0);
            done++;
         end else begin
            send_word(CMD_CAPTURE, CH_W'($urandom_range(0, CHANNELS - 1)), draw_stamp(),
                      1'b0, '0);
            done++;
         end
      end
   endtask

   initial begin
      int stall;
      int taken;
      taken = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 40 == 0) begin
            recv_stalls_on = ($urandom_range(0, 3) != 0);
         end
         stall = recv_stalls_on ? $urandom_range(0, GAP_MAX) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_result();
         taken++;
      end
   end

   initial begin
      stim_row_type        directed [20];
      logic [RELOAD_W-1:0] reload_plan [PHASES];
      req_bus.valid         <= 1'b0;
      req_bus.cmd           <= CMD_OVERFLOW;
      req_bus.channel       <= '0;
      req_bus.capture_value <= '0;
      csr_write_enable      <= 1'b0;
      csr_write_data        <= '0;
      reload_q = int'(RELOAD_RESET);
      for (int i = 0; i < CHANNELS; i++) begin
         armed_q[i] = 1'b0;
         wraps_q[i] = 0;
         start_q[i] = 0;
         width_q[i] = 0;
      end
      directed = '{
         '{CMD_MIX,      CH_ROLL,   16'd0,     1'b1, MIX_CLEARED},
         '{CMD_CAPTURE,  CH_ROLL,   16'd100,   1'b0, '0},
         '{CMD_CAPTURE,  CH_ROLL,   16'd50,    1'b1, measured(CH_ROLL, 0)},
         '{CMD_CAPTURE,  CH_PITCH,  16'd0,     1'b0, '0},
         '{CMD_OVERFLOW, CH_PITCH,  16'd0,     1'b0, '0},
         '{CMD_CAPTURE,  CH_PITCH,  16'hFFFF,  1'b0, '0},
         '{CMD_CAPTURE,  CH_AUX1,   16'hFFFF,  1'b0, '0},
         '{CMD_CAPTURE,  CH_AUX1,   16'hFFFF,  1'b1, measured(CH_AUX1, 0)},
         '{CMD_CAPTURE,  CH_AUX2,   16'd1000,  1'b0, '0},
         '{CMD_CAPTURE,  CH_AUX2,   16'd3000,  1'b0, '0},
         '{CMD_CAPTURE,  CH_THRUST, 16'd0,     1'b0, '0},
         '{CMD_CAPTURE,  CH_THRUST, 16'hFFFF,  1'b1, measured(CH_THRUST, 65535)},
         '{CMD_CAPTURE,  CH_YAW,    16'd10,    1'b0, '0},
         '{CMD_CAPTURE,  CH_YAW,    16'd20,    1'b0, '0},
         '{CMD_CAPTURE,  3'd6,      16'h5555,  1'b0, '0},
         '{CMD_CAPTURE,  3'd7,      16'hAAAA,  1'b0, '0},
         '{CMD_UNUSED,   CH_YAW,    16'hFFFF,  1'b0, '0},
         '{CMD_MIX,      CH_ROLL,   16'd0,     1'b0, '0},
         '{CMD_MIX,      CH_ROLL,   16'd0,     1'b1, MIX_CLEARED},
         '{CMD_OVERFLOW, 3'd7,      16'hFFFF,  1'b0, '0}
      };
      reload_plan = '{16'd0, 16'hFFFF, 16'd1, RELOAD_W'($urandom), 16'd300,
                      RELOAD_W'($urandom)};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         send_word(directed[i].cmd, directed[i].chan, directed[i].stamp, directed[i].typed,
                   directed[i].want);
      end
      for (int p = 0; p < PHASES; p++) begin
         write_reload(reload_plan[p]);
         run_random(PHASE_WORDS);
      end
      settle();
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
